FILE: hw/rtl/two_axis_encoder_goto_controller_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-axis encoder goto controller.
// Shared forms for concurrent checks on a single clock with a reset guard.
// ----------------------------------------------------------------------------
`ifndef TWO_AXIS_ENCODER_GOTO_CONTROLLER_CORE_MACROS_SVH
`define TWO_AXIS_ENCODER_GOTO_CONTROLLER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TAEGC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("controller check failed");

// The consequent must hold in the cycle after the antecedent.
`define TAEGC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("controller check failed");

`endif

FILE: hw/rtl/taegc_pkg.sv
// ----------------------------------------------------------------------------
// taegc_pkg
// Types, codes and constants shared by the two-axis goto controller files.
// ----------------------------------------------------------------------------
package taegc_pkg;

  // Counts per revolution of either axis.
  localparam int unsigned REV_COUNTS  = 1171814;
  localparam int unsigned DUTY_MAX    = (1 << 7) - 1;
  localparam int          DUTY_W      = 7;
  localparam int          COUNT_W     = 32;
  localparam int          POS_W       = 16;
  localparam int          VZERO_W     = 21;
  localparam int          CFG_INDEX_W = 2;
  localparam int          CFG_DATA_W  = 21;

  // Reset values of the configuration registers.
  localparam logic [VZERO_W-1:0] VZERO_RESET     = VZERO_W'(REV_COUNTS / 4);
  localparam logic [DUTY_W-1:0]  GOTO_DUTY_RESET = DUTY_W'(DUTY_MAX);

  // Command codes as they arrive on the input channel.
  typedef enum logic [2:0] {
    MODE_TICK  = 3'd0,
    MODE_MOVE  = 3'd1,
    MODE_GOTO  = 3'd2,
    MODE_ZERO  = 3'd3,
    MODE_QUERY = 3'd4
  } mode_t;

  // Classified operations carried through the queue.
  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_MOVE  = 3'd1,
    OP_GOTO  = 3'd2,
    OP_ZERO  = 3'd3,
    OP_QUERY = 3'd4,
    OP_NOP   = 3'd5
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_VZERO     = 2'd0,
    CFG_GOTO_DUTY = 2'd1
  } cfg_index_t;

  // One classified command word.
  typedef struct packed {
    op_t                op;
    logic               axis;
    logic               dir_level;
    logic [COUNT_W-1:0] horiz_value;
    logic [COUNT_W-1:0] vert_value;
    logic [DUTY_W-1:0]  horiz_duty;
    logic [DUTY_W-1:0]  vert_duty;
  } cmd_t;

  // Head of the command queue as seen by the back end.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_slot_t;

  // Bridge pins and duty of one axis.
  typedef struct packed {
    logic              in_a;
    logic              in_b;
    logic [DUTY_W-1:0] duty;
  } bridge_t;

  // Executed command: bridge state plus a snapshot of both counts.
  typedef struct packed {
    bridge_t            horiz;
    bridge_t            vert;
    logic               drive_enable;
    logic               position_valid;
    logic [COUNT_W-1:0] horiz_count;
    logic [COUNT_W-1:0] vert_count;
  } exec_word_t;

  typedef struct packed {
    logic       valid;
    exec_word_t word;
  } exec_slot_t;

endpackage

FILE: hw/rtl/taegc_if.sv
// ----------------------------------------------------------------------------
// taegc_cmd_if / taegc_result_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface taegc_cmd_if;
  logic                               valid;
  logic                               ready;
  logic [2:0]                         mode;
  logic                               axis;
  logic                               dir_level;
  logic signed [taegc_pkg::COUNT_W-1:0] horiz_value;
  logic signed [taegc_pkg::COUNT_W-1:0] vert_value;

  modport source (output valid, mode, axis, dir_level, horiz_value, vert_value,
                  input ready);
  modport sink   (input valid, mode, axis, dir_level, horiz_value, vert_value,
                  output ready);
endinterface

interface taegc_result_if;
  logic                            valid;
  logic                            ready;
  logic                            horiz_in_a;
  logic                            horiz_in_b;
  logic [taegc_pkg::DUTY_W-1:0]    horiz_duty;
  logic                            vert_in_a;
  logic                            vert_in_b;
  logic [taegc_pkg::DUTY_W-1:0]    vert_duty;
  logic                            drive_enable;
  logic                            position_valid;
  logic [taegc_pkg::POS_W-1:0]     horiz_position;
  logic [taegc_pkg::POS_W-1:0]     vert_position;

  modport source (output valid, horiz_in_a, horiz_in_b, horiz_duty, vert_in_a,
                         vert_in_b, vert_duty, drive_enable, position_valid,
                         horiz_position, vert_position,
                  input ready);
  modport sink   (input valid, horiz_in_a, horiz_in_b, horiz_duty, vert_in_a,
                        vert_in_b, vert_duty, drive_enable, position_valid,
                        horiz_position, vert_position,
                  output ready);
endinterface

FILE: hw/rtl/taegc_front.sv
// ----------------------------------------------------------------------------
// taegc_front
// Accepts command words, classifies them and works out move duties.
// ----------------------------------------------------------------------------
module taegc_front (
  taegc_cmd_if.sink              cmd,
  input  logic                   full,
  output logic                   push_valid,
  output taegc_pkg::cmd_t        push_word
);

  // Duty for a signed speed: floor(127 * |v| / (2^31 - 1)).
  // 127*m is split as q * 2^31 + r, so the true quotient is q or q + 1.
  function automatic logic [taegc_pkg::DUTY_W-1:0] speed_duty(
    logic [taegc_pkg::COUNT_W-1:0] v
  );
    logic [taegc_pkg::COUNT_W-1:0] mag;
    logic [taegc_pkg::COUNT_W+6:0] prod;
    logic [7:0]                    q;
    logic [taegc_pkg::COUNT_W:0]   sum;
    mag  = v[taegc_pkg::COUNT_W-1] ? (~v + 1'b1) : v;
    prod = {mag, 7'd0} - {7'd0, mag};
    q    = prod[taegc_pkg::COUNT_W+6:taegc_pkg::COUNT_W-1];
    sum  = {25'd0, q} + {2'd0, prod[taegc_pkg::COUNT_W-2:0]};
    if (sum >= {2'd0, {(taegc_pkg::COUNT_W-1){1'b1}}}) begin
      q = q + 8'd1;
    end
    return q[taegc_pkg::DUTY_W-1:0];
  endfunction

  assign cmd.ready  = !full;
  assign push_valid = cmd.valid;

  // Classify the mode and precompute both move duties.
  always_comb begin
    push_word.axis        = cmd.axis;
    push_word.dir_level   = cmd.dir_level;
    push_word.horiz_value = cmd.horiz_value;
    push_word.vert_value  = cmd.vert_value;
    push_word.horiz_duty  = speed_duty(cmd.horiz_value);
    push_word.vert_duty   = speed_duty(cmd.vert_value);
    unique case (taegc_pkg::mode_t'(cmd.mode))
      taegc_pkg::MODE_TICK:  push_word.op = taegc_pkg::OP_TICK;
      taegc_pkg::MODE_MOVE:  push_word.op = taegc_pkg::OP_MOVE;
      taegc_pkg::MODE_GOTO:  push_word.op = taegc_pkg::OP_GOTO;
      taegc_pkg::MODE_ZERO:  push_word.op = taegc_pkg::OP_ZERO;
      taegc_pkg::MODE_QUERY: push_word.op = taegc_pkg::OP_QUERY;
      default:               push_word.op = taegc_pkg::OP_NOP;
    endcase
  end

endmodule

FILE: hw/rtl/taegc_queue.sv
// ----------------------------------------------------------------------------
// taegc_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module taegc_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  input  taegc_pkg::cmd_t      push_word,
  output logic                 full,
  output taegc_pkg::cmd_slot_t head,
  input  logic                 pop
);

  localparam int DEPTH  = 2;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);

  taegc_pkg::cmd_t   slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              push;
  logic              pull;

  assign full       = (fill == FILL_W'(DEPTH));
  assign push       = push_valid && !full;
  assign pull       = pop && (fill != '0);
  assign head.valid = (fill != '0);
  assign head.cmd   = slots[rd_ptr];

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= PTR_W'(wr_ptr + 1'b1);
      end
      if (pull) begin
        rd_ptr <= PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pull) begin
        fill <= FILL_W'(fill + 1'b1);
      end else if (pull && !push) begin
        fill <= FILL_W'(fill - 1'b1);
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

endmodule

FILE: hw/rtl/taegc_exec.sv
// ----------------------------------------------------------------------------
// taegc_exec
// Back end: holds counts, targets and bridge state and applies commands.
// ----------------------------------------------------------------------------
module taegc_exec (
  input  logic                               clk,
  input  logic                               rst,
  input  taegc_pkg::cmd_slot_t               head,
  output logic                               pop,
  input  logic [taegc_pkg::VZERO_W-1:0]      vzero,
  input  logic [taegc_pkg::DUTY_W-1:0]       goto_duty,
  output taegc_pkg::exec_slot_t              stage,
  input  logic                               stage_ready
);

  logic [taegc_pkg::COUNT_W-1:0] hcount, hcount_next;
  logic [taegc_pkg::COUNT_W-1:0] vcount, vcount_next;
  logic [taegc_pkg::COUNT_W-1:0] htarget, htarget_next;
  logic [taegc_pkg::COUNT_W-1:0] vtarget, vtarget_next;
  logic                          hactive, hactive_next;
  logic                          vactive, vactive_next;
  taegc_pkg::bridge_t            hbridge, hbridge_next;
  taegc_pkg::bridge_t            vbridge, vbridge_next;
  logic                          drive_en, drive_en_next;
  logic                          load;
  taegc_pkg::cmd_t               c;

  assign load = !stage.valid || stage_ready;
  assign pop  = head.valid && load;
  assign c    = head.cmd;

  // Next state for the command at the head of the queue.
  always_comb begin
    hcount_next   = hcount;
    vcount_next   = vcount;
    htarget_next  = htarget;
    vtarget_next  = vtarget;
    hactive_next  = hactive;
    vactive_next  = vactive;
    hbridge_next  = hbridge;
    vbridge_next  = vbridge;
    drive_en_next = drive_en;
    if (pop) begin
      unique case (c.op)
        taegc_pkg::OP_TICK: begin
          if (c.axis) begin
            vcount_next = c.dir_level ? vcount + 1'b1 : vcount - 1'b1;
            if (vactive && (vcount_next == vtarget)) begin
              vbridge_next  = '0;
              vactive_next  = 1'b0;
              drive_en_next = 1'b1;
            end
          end else begin
            hcount_next = c.dir_level ? hcount - 1'b1 : hcount + 1'b1;
            if (hactive && (hcount_next == htarget)) begin
              hbridge_next  = '0;
              hactive_next  = 1'b0;
              drive_en_next = 1'b1;
            end
          end
        end
        taegc_pkg::OP_MOVE: begin
          hbridge_next.in_a = c.horiz_value[taegc_pkg::COUNT_W-1];
          hbridge_next.in_b = !c.horiz_value[taegc_pkg::COUNT_W-1];
          hbridge_next.duty = c.horiz_duty;
          vbridge_next.in_a = c.vert_value[taegc_pkg::COUNT_W-1];
          vbridge_next.in_b = !c.vert_value[taegc_pkg::COUNT_W-1];
          vbridge_next.duty = c.vert_duty;
          if (c.horiz_duty == '0) begin
            hactive_next = 1'b0;
          end
          if (c.vert_duty == '0) begin
            vactive_next = 1'b0;
          end
          drive_en_next = 1'b1;
        end
        taegc_pkg::OP_GOTO: begin
          htarget_next = c.horiz_value;
          vtarget_next = c.vert_value;
          hactive_next = 1'b1;
          vactive_next = 1'b1;
          // Horizontal drives with its direction inverted.
          if ($signed(c.horiz_value) != $signed(hcount)) begin
            if ($signed(c.horiz_value) > $signed(hcount)) begin
              hbridge_next.in_a = 1'b1;
              hbridge_next.in_b = 1'b0;
            end else begin
              hbridge_next.in_a = 1'b0;
              hbridge_next.in_b = 1'b1;
            end
            hbridge_next.duty = goto_duty;
            drive_en_next     = 1'b1;
            if (goto_duty == '0) begin
              hactive_next = 1'b0;
            end
          end
          if ($signed(c.vert_value) != $signed(vcount)) begin
            if ($signed(c.vert_value) > $signed(vcount)) begin
              vbridge_next.in_a = 1'b0;
              vbridge_next.in_b = 1'b1;
            end else begin
              vbridge_next.in_a = 1'b1;
              vbridge_next.in_b = 1'b0;
            end
            vbridge_next.duty = goto_duty;
            drive_en_next     = 1'b1;
            if (goto_duty == '0) begin
              vactive_next = 1'b0;
            end
          end
        end
        taegc_pkg::OP_ZERO: begin
          hcount_next = '0;
          vcount_next = taegc_pkg::COUNT_W'(vzero);
        end
        taegc_pkg::OP_QUERY: begin
        end
        taegc_pkg::OP_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Axis state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      hcount   <= '0;
      vcount   <= '0;
      htarget  <= '0;
      vtarget  <= '0;
      hactive  <= 1'b1;
      vactive  <= 1'b1;
      hbridge  <= '0;
      vbridge  <= '0;
      drive_en <= 1'b0;
    end else begin
      hcount   <= hcount_next;
      vcount   <= vcount_next;
      htarget  <= htarget_next;
      vtarget  <= vtarget_next;
      hactive  <= hactive_next;
      vactive  <= vactive_next;
      hbridge  <= hbridge_next;
      vbridge  <= vbridge_next;
      drive_en <= drive_en_next;
    end
  end

  // Executed word register toward the position scaler.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (load) begin
      stage.valid <= head.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage.word.horiz          <= hbridge_next;
      stage.word.vert           <= vbridge_next;
      stage.word.drive_enable   <= drive_en_next;
      stage.word.position_valid <= (c.op == taegc_pkg::OP_QUERY);
      stage.word.horiz_count    <= hcount_next;
      stage.word.vert_count     <= vcount_next;
    end
  end

endmodule

FILE: hw/rtl/taegc_scale.sv
// ----------------------------------------------------------------------------
// taegc_scale
// Scales both count snapshots to 16-bit revolution fractions and drives
// the result channel from its output register.
// ----------------------------------------------------------------------------
module taegc_scale (
  input  logic                   clk,
  input  logic                   rst,
  input  taegc_pkg::exec_slot_t  stage,
  output logic                   stage_ready,
  taegc_result_if.source         result
);

  // q = floor(c * 65535 / REV) for 0 < c < REV is first estimated with a
  // reciprocal (low by at most one), then corrected from the remainder.
  localparam int C_W = $clog2(taegc_pkg::REV_COUNTS);
  localparam int P_W = C_W + taegc_pkg::POS_W;
  localparam logic [16:0] SCALE_RECIP =
    17'((64'd65535 << C_W) / 64'(taegc_pkg::REV_COUNTS));
  localparam logic [C_W-1:0] REV_K = C_W'(taegc_pkg::REV_COUNTS);

  typedef struct packed {
    logic                          zero;
    logic                          sat;
    logic [C_W-1:0]                c;
    logic [taegc_pkg::POS_W-1:0]   q;
  } lane_t;

  logic                          a_valid, b_valid, o_valid;
  logic                          a_load, b_load, o_load;
  taegc_pkg::exec_word_t         a_word, b_word, o_word;
  lane_t                         a_lane_d [2];
  lane_t                         a_lane [2];
  lane_t                         b_lane [2];
  logic [P_W-1:0]                b_prod_d [2];
  logic [P_W-1:0]                b_prod [2];
  logic [taegc_pkg::POS_W-1:0]   o_pos_d [2];
  logic [taegc_pkg::POS_W-1:0]   o_pos [2];
  logic [taegc_pkg::COUNT_W-1:0] counts [2];
  logic [C_W+16:0]               est [2];
  logic [P_W-1:0]                x [2];
  logic [P_W-1:0]                rem [2];

  assign o_load      = !o_valid || result.ready;
  assign b_load      = !b_valid || o_load;
  assign a_load      = !a_valid || b_load;
  assign stage_ready = a_load;

  assign counts[0] = stage.word.horiz_count;
  assign counts[1] = stage.word.vert_count;

  // Range flags and reciprocal estimate.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      a_lane_d[i].zero = counts[i][taegc_pkg::COUNT_W-1] || (counts[i] == '0);
      a_lane_d[i].sat  = (counts[i] >= taegc_pkg::COUNT_W'(taegc_pkg::REV_COUNTS));
      a_lane_d[i].c    = counts[i][C_W-1:0];
      est[i]           = (C_W+17)'(counts[i][C_W-1:0]) * (C_W+17)'(SCALE_RECIP);
      a_lane_d[i].q    = est[i][C_W+taegc_pkg::POS_W-1:C_W];
    end
  end

  // Estimate times the divisor.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      b_prod_d[i] = P_W'(a_lane[i].q) * P_W'(REV_K);
    end
  end

  // Remainder correction, saturation and query gating.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      x[i]   = {b_lane[i].c, {taegc_pkg::POS_W{1'b0}}} - P_W'(b_lane[i].c);
      rem[i] = x[i] - b_prod[i];
      if (!b_word.position_valid || b_lane[i].zero) begin
        o_pos_d[i] = '0;
      end else if (b_lane[i].sat) begin
        o_pos_d[i] = '1;
      end else if (rem[i] >= P_W'(REV_K)) begin
        o_pos_d[i] = b_lane[i].q + 1'b1;
      end else begin
        o_pos_d[i] = b_lane[i].q;
      end
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (a_load) begin
        a_valid <= stage.valid;
      end
      if (b_load) begin
        b_valid <= a_valid;
      end
      if (o_load) begin
        o_valid <= b_valid;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (a_load) begin
      a_word <= stage.word;
      a_lane <= a_lane_d;
    end
    if (b_load) begin
      b_word <= a_word;
      b_lane <= a_lane;
      b_prod <= b_prod_d;
    end
    if (o_load) begin
      o_word <= b_word;
      o_pos  <= o_pos_d;
    end
  end

  assign result.valid          = o_valid;
  assign result.horiz_in_a     = o_word.horiz.in_a;
  assign result.horiz_in_b     = o_word.horiz.in_b;
  assign result.horiz_duty     = o_word.horiz.duty;
  assign result.vert_in_a      = o_word.vert.in_a;
  assign result.vert_in_b      = o_word.vert.in_b;
  assign result.vert_duty      = o_word.vert.duty;
  assign result.drive_enable   = o_word.drive_enable;
  assign result.position_valid = o_word.position_valid;
  assign result.horiz_position = o_pos[0];
  assign result.vert_position  = o_pos[1];

endmodule

FILE: hw/rtl/two_axis_encoder_goto_controller_core.sv
// ----------------------------------------------------------------------------
// two_axis_encoder_goto_controller_core
// Two-axis mount controller: encoder counting, move, goto and position query.
// ----------------------------------------------------------------------------
//
//   channel   kind           words
//   -------   ------------   -----------------------------------------------
//   cmd       valid/ready    mode, axis, dir_level, horiz_value, vert_value
//   result    valid/ready    bridge pins and duties, enable, positions
//   cfg_*     write only     vertical_zero_position, goto_duty
//
// One command word is taken per cycle while cmd.ready is high, and each gives
// one result word. Before result valid, it passes the queue, the execute
// register, then the two multiplier stages and the output register of the scaler.
// Reset is synchronous; both targets come up active at zero, all pins low.
// A stalled result holds the scaler and the execute stage; the two-entry
// queue then absorbs words until it is full and cmd.ready drops.
// ----------------------------------------------------------------------------
`include "two_axis_encoder_goto_controller_core_macros.svh"

module two_axis_encoder_goto_controller_core (
  input  logic                                clk,
  input  logic                                rst,
  taegc_cmd_if.sink                           cmd,
  taegc_result_if.source                      result,
  input  logic                                cfg_we,
  input  logic [taegc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [taegc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [taegc_pkg::VZERO_W-1:0] vzero;
  logic [taegc_pkg::DUTY_W-1:0]  goto_duty;
  logic                          push_valid;
  taegc_pkg::cmd_t               push_word;
  logic                          full;
  taegc_pkg::cmd_slot_t          head;
  logic                          pop;
  taegc_pkg::exec_slot_t         stage;
  logic                          stage_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      vzero     <= taegc_pkg::VZERO_RESET;
      goto_duty <= taegc_pkg::GOTO_DUTY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        taegc_pkg::CFG_VZERO:     vzero     <= cfg_data[taegc_pkg::VZERO_W-1:0];
        taegc_pkg::CFG_GOTO_DUTY: goto_duty <= cfg_data[taegc_pkg::DUTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  taegc_front u_front (
    .cmd        (cmd),
    .full       (full),
    .push_valid (push_valid),
    .push_word  (push_word)
  );

  taegc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_word  (push_word),
    .full       (full),
    .head       (head),
    .pop        (pop)
  );

  taegc_exec u_exec (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .vzero       (vzero),
    .goto_duty   (goto_duty),
    .stage       (stage),
    .stage_ready (stage_ready)
  );

  taegc_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .stage       (stage),
    .stage_ready (stage_ready),
    .result      (result)
  );

  // A bridge never drives both inputs high.
  `TAEGC_ASSERT_NOW(a_bridge_legal, clk, rst, result.valid,
    !(result.horiz_in_a && result.horiz_in_b) && !(result.vert_in_a && result.vert_in_b))
  // Positions read zero on every word that does not answer a query.
  `TAEGC_ASSERT_NOW(a_pos_gated, clk, rst, result.valid && !result.position_valid,
    (result.horiz_position == '0) && (result.vert_position == '0))
  // Once the motors are enabled, no later word shows them disabled.
  `TAEGC_ASSERT_NEXT(a_enable_sticky, clk, rst, result.valid && result.drive_enable,
    !result.valid || result.drive_enable)
  // The back end only pops a queue that holds a word.
  `TAEGC_ASSERT_NOW(a_pop_nonempty, clk, rst, pop, head.valid)

endmodule
